// ----- src/dtp_pkg.sv -----
package dtp_pkg;

   // Build-time options
   localparam int FLIP_MODE  = 0;
   localparam int COORD_BITS = 12;

   // Field widths
   localparam int COL_W   = 12;
   localparam int DISP_W  = 16;
   localparam int COLOR_W = 8;
   localparam int ENTRY_W = 33;   // Q16.16 entry plus room for negation
   localparam int VEC_W   = 17;   // Q.4 vector element
   localparam int PROD_W  = ENTRY_W + VEC_W;
   localparam int SUM_W   = PROD_W + 2;
   localparam int COORD_W = 32;
   localparam int QUO_W   = 32;
   localparam int FRAC_W  = 16;
   localparam int NUM_REGS = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W   = 64;

   // Divider latency: operand stage, one stage per quotient bit, result stage
   localparam int DIV_LATENCY = QUO_W + 2;

   localparam int USED_COORD_BITS = (COORD_BITS < COL_W) ? COORD_BITS : COL_W;
   localparam logic [COL_W-1:0] COORD_MASK = COL_W'((64'd1 << USED_COORD_BITS) - 64'd1);

   localparam logic [COORD_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
   localparam logic [COORD_W-1:0] NEG_LIMIT = 32'h8000_0000;

   typedef logic signed [SUM_W-1:0] sum_type;

   // Control and colour carried alongside the dividers
   typedef struct packed {
      logic               valid;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } side_type;

endpackage

// ----- src/disparity_to_point_reprojection.sv -----
// Channel | Dir | Ports                  | Word
// req     | in  | req_tvalid/tready/tdata| col[11:0] row[23:12] disp[39:24] r g b[63:40]
// rsp     | out | rsp_tvalid/tready/tdata/tuser | x y z[95:0] r g b[119:96]; tuser sat
// csr     | in  | csr_we/csr_index/csr_wdata | one 64-bit matrix register per write
// One pixel per cycle while the output is not stalled; the divider pipeline resolves 32 quotient bits, one per stage.
// Pixels failing the depth test leave the pipeline without a result word.
// Reset (synchronous) clears the matrix registers and all valid bits.
// A stalled output freezes the whole pipeline; req_tready drops for that cycle.
module disparity_to_point_reprojection (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [63:0]                  req_tdata,  // pixel_column, pixel_row, disparity,
                                                    // red_in, green_in, blue_in
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [119:0]                 rsp_tdata,  // point_x, point_y, point_z,
                                                    // red_out, green_out, blue_out
   output logic                         rsp_tuser,  // saturated
   input  logic                         csr_we,
   input  logic [dtp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dtp_pkg::CSR_W-1:0]    csr_wdata
);
   import dtp_pkg::*;

   logic [CSR_W-1:0] q_ff [0:NUM_REGS-1];
   logic             advance;

   // Matrix registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) q_ff[i] <= '0;
      end else if (csr_we) begin
         q_ff[csr_index] <= csr_wdata;
      end
   end

   // Hold everything while a result word waits
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // Stage A: form the vector
   logic signed [VEC_W-1:0] vec_ff [0:3];
   side_type                a_ff;
   logic [COL_W-1:0]        col_m, row_m;
   logic signed [DISP_W-1:0] disp;
   logic                    disp_ok;

   always_comb begin
      col_m   = req_tdata[11:0] & COORD_MASK;
      row_m   = req_tdata[23:12] & COORD_MASK;
      disp    = $signed(req_tdata[39:24]);
      disp_ok = !disp[DISP_W-1] && (disp != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) a_ff.valid <= 1'b0;
      else if (advance) a_ff.valid <= req_tvalid;
      if (advance) begin
         a_ff.red   <= req_tdata[47:40];
         a_ff.green <= req_tdata[55:48];
         a_ff.blue  <= req_tdata[63:56];
         vec_ff[0]  <= disp_ok ? $signed({1'b0, col_m, 4'b0}) : '0;
         vec_ff[1]  <= disp_ok ? $signed({1'b0, row_m, 4'b0}) : '0;
         vec_ff[2]  <= disp_ok ? VEC_W'(disp) : -VEC_W'(16);
         vec_ff[3]  <= VEC_W'(16);
      end
   end

   // Stage B: sixteen products
   logic signed [PROD_W-1:0] prod_ff [0:15];
   side_type                 b_ff;

   for (genvar r = 0; r < 4; r++) begin : g_row
      for (genvar c = 0; c < 4; c++) begin : g_col
         localparam bit NEGATE = (FLIP_MODE != 0) &&
            ((r == 1 && c == 1) || (r == 1 && c == 3) || (r == 2 && c == 3));
         logic [31:0]              half;
         logic signed [ENTRY_W-1:0] entry;
         always_comb begin
            half  = q_ff[r*2 + c/2][(c%2)*32 +: 32];
            entry = NEGATE ? -ENTRY_W'($signed(half)) : ENTRY_W'($signed(half));
         end
         always_ff @(posedge clock) begin
            if (advance) prod_ff[r*4+c] <= PROD_W'(entry) * PROD_W'(vec_ff[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) b_ff.valid <= 1'b0;
      else if (advance) b_ff <= a_ff;
   end

   // Stage C: row sums and the depth test
   sum_type h_ff [0:3];
   side_type c_ff;
   sum_type  h_in [0:3];
   logic     pass;

   always_comb begin
      for (int r = 0; r < 4; r++)
         h_in[r] = SUM_W'(prod_ff[r*4]) + SUM_W'(prod_ff[r*4+1])
                 + SUM_W'(prod_ff[r*4+2]) + SUM_W'(prod_ff[r*4+3]);
      if (FLIP_MODE != 0) pass = h_in[2][SUM_W-1];
      else pass = !h_in[2][SUM_W-1] && (h_in[2] != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) c_ff.valid <= 1'b0;
      else if (advance) c_ff.valid <= b_ff.valid && pass;
      if (advance) begin
         c_ff.red   <= b_ff.red;
         c_ff.green <= b_ff.green;
         c_ff.blue  <= b_ff.blue;
         for (int r = 0; r < 4; r++) h_ff[r] <= h_in[r];
      end
   end

   // Dividers and the matching side line
   logic [COORD_W-1:0] px, py, pz;
   logic               sx, sy, sz;

   dtp_div u_div_x (.clock, .advance, .num(h_ff[0]), .den(h_ff[3]), .quo(px), .sat(sx));
   dtp_div u_div_y (.clock, .advance, .num(h_ff[1]), .den(h_ff[3]), .quo(py), .sat(sy));
   dtp_div u_div_z (.clock, .advance, .num(h_ff[2]), .den(h_ff[3]), .quo(pz), .sat(sz));

   side_type side_ff [0:DIV_LATENCY-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LATENCY; i++) side_ff[i].valid <= 1'b0;
      end else if (advance) begin
         side_ff[0] <= c_ff;
         for (int i = 1; i < DIV_LATENCY; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   assign rsp_tvalid = side_ff[DIV_LATENCY-1].valid;
   assign rsp_tdata  = {side_ff[DIV_LATENCY-1].blue, side_ff[DIV_LATENCY-1].green,
                        side_ff[DIV_LATENCY-1].red, pz, py, px};
   assign rsp_tuser  = sx || sy || sz;

endmodule

// ----- src/dtp_div.sv -----
module dtp_div (
   input  logic                          clock,
   input  logic                          advance,
   input  dtp_pkg::sum_type              num,
   input  dtp_pkg::sum_type              den,
   output logic [dtp_pkg::COORD_W-1:0]   quo,
   output logic                          sat
);
   import dtp_pkg::*;

   localparam int STEPS = QUO_W;

   logic [SUM_W-1:0] an_ff  [0:STEPS];
   logic [SUM_W-1:0] ad_ff  [0:STEPS];
   logic [SUM_W-1:0] rem_ff [0:STEPS];
   logic [QUO_W-1:0] q_ff   [0:STEPS];
   logic             neg_ff [0:STEPS];
   logic             negn_ff[0:STEPS];
   logic             zden_ff[0:STEPS];
   logic             nzn_ff [0:STEPS];
   logic             ovf_ff [0:STEPS];
   logic [COORD_W-1:0] quo_ff;
   logic               sat_ff;

   logic [SUM_W-1:0] an_in;
   logic [SUM_W-1:0] ad_in;

   // Take magnitudes and signs
   always_comb begin
      an_in = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
      ad_in = den[SUM_W-1] ? SUM_W'(-den) : SUM_W'(den);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         an_ff[0]   <= an_in;
         ad_ff[0]   <= ad_in;
         rem_ff[0]  <= SUM_W'(an_in >> FRAC_W);
         q_ff[0]    <= '0;
         negn_ff[0] <= num[SUM_W-1];
         neg_ff[0]  <= num[SUM_W-1] ^ den[SUM_W-1];
         zden_ff[0] <= (ad_in == '0);
         nzn_ff[0]  <= (an_in != '0);
         ovf_ff[0]  <= (SUM_W'(an_in >> FRAC_W) >= ad_in);
      end
   end

   // One quotient bit per stage, most significant first
   for (genvar k = 1; k <= STEPS; k++) begin : g_step
      localparam int BIT = STEPS - k;
      logic            nbit;
      logic [SUM_W:0]  trial;
      // Shift in the low dividend bits, then zeros for the fraction
      if (BIT >= FRAC_W) begin : g_int
         assign nbit = an_ff[k-1][BIT-FRAC_W];
      end else begin : g_frac
         assign nbit = 1'b0;
      end
      always_comb begin
         trial = {rem_ff[k-1], nbit};
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            an_ff[k]   <= an_ff[k-1];
            ad_ff[k]   <= ad_ff[k-1];
            negn_ff[k] <= negn_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
            zden_ff[k] <= zden_ff[k-1];
            nzn_ff[k]  <= nzn_ff[k-1];
            ovf_ff[k]  <= ovf_ff[k-1];
            if (trial >= {1'b0, ad_ff[k-1]}) begin
               rem_ff[k]    <= SUM_W'(trial - {1'b0, ad_ff[k-1]});
               q_ff[k]      <= q_ff[k-1] | (QUO_W'(1) << BIT);
            end else begin
               rem_ff[k]    <= SUM_W'(trial);
               q_ff[k]      <= q_ff[k-1];
            end
         end
      end
   end

   logic [COORD_W-1:0] quo_in;
   logic               sat_in;
   logic [COORD_W-1:0] limit;

   // Apply sign, limits and the zero-denominator rule
   always_comb begin
      limit = neg_ff[STEPS] ? NEG_LIMIT : POS_LIMIT;
      if (zden_ff[STEPS]) begin
         sat_in = 1'b1;
         if (!nzn_ff[STEPS]) quo_in = '0;
         else quo_in = negn_ff[STEPS] ? NEG_LIMIT : POS_LIMIT;
      end else if (ovf_ff[STEPS] || (q_ff[STEPS] > limit)) begin
         sat_in = 1'b1;
         quo_in = limit;
      end else begin
         sat_in = 1'b0;
         quo_in = neg_ff[STEPS] ? COORD_W'(-q_ff[STEPS]) : q_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         quo_ff <= quo_in;
         sat_ff <= sat_in;
      end
   end

   assign quo = quo_ff;
   assign sat = sat_ff;

endmodule

// ----- src/dtp_checker.sv -----
module dtp_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [119:0] rsp_tdata,
   input logic         rsp_tuser
);
   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid after reset");

   // Input is only held back by a waiting result
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with no waiting result");

   // A stalled result word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

endmodule

bind disparity_to_point_reprojection dtp_checker u_dtp_checker (
   .clock, .reset, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import dtp_pkg::*;

   localparam int DRAIN_CYCLES = 60;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [63:0]   req_tdata = '0;   // pixel_column, pixel_row, disparity, red, green, blue
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [119:0]  rsp_tdata;        // point_x, point_y, point_z, red, green, blue
   logic          rsp_tuser;        // saturated
   logic          csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   typedef struct packed {
      logic        sat;
      logic [23:0] rgb;
      logic [95:0] xyz;
   } point_type;

   logic [63:0] q_matrix [NUM_REGS];
   point_type   expected_points [$];
   int          mismatch_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;

   disparity_to_point_reprojection dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Matrix entry as a signed value, with the flip-mode negation applied
   function automatic longint q_at(int r, int c);
      logic [63:0] reg_val;
      logic [31:0] half;
      longint v;
      reg_val = q_matrix[r * 2 + c / 2];
      half = c[0] ? reg_val[63:32] : reg_val[31:0];
      v = longint'($signed(half));
      if (FLIP_MODE != 0 && ((r == 1 && (c == 1 || c == 3)) || (r == 2 && c == 3)))
         v = -v;
      return v;
   endfunction

   // Signed Q15.16 quotient, truncated toward zero, saturating
   function automatic logic [31:0] divide_q16(longint num, longint den, ref logic sat);
      logic [63:0] an, ad, q, r, m, limit;
      logic neg;
      an = num < 0 ? -num : num;
      ad = den < 0 ? -den : den;
      if (ad == 0) begin
         sat = 1'b1;
         if (an == 0) return '0;
         return num < 0 ? NEG_LIMIT : POS_LIMIT;
      end
      neg = (num < 0) != (den < 0);
      limit = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      q = an / ad;
      r = an % ad;
      if (q >= 64'h10000) begin
         sat = 1'b1;
         return neg ? NEG_LIMIT : POS_LIMIT;
      end
      m = q << 16;
      for (int i = 15; i >= 0; i--) begin
         r = r << 1;
         if (r >= ad) begin
            r = r - ad;
            m[i] = 1'b1;
         end
      end
      if (m > limit) begin
         sat = 1'b1;
         return neg ? NEG_LIMIT : POS_LIMIT;
      end
      return neg ? 32'(-m) : m[31:0];
   endfunction

   // Reproject one pixel; queue a point only if it passes the depth test
   function automatic void project_pixel(logic [63:0] word);
      longint vec [4];
      longint h [4];
      logic signed [15:0] disp;
      logic pass;
      logic sat;
      point_type pt;
      disp = word[39:24];
      if (disp > 0) begin
         vec[0] = longint'(word[11:0] & COORD_MASK) * 16;
         vec[1] = longint'(word[23:12] & COORD_MASK) * 16;
         vec[2] = disp;
      end else begin
         vec[0] = 0;
         vec[1] = 0;
         vec[2] = -16;
      end
      vec[3] = 16;
      for (int r = 0; r < 4; r++) begin
         h[r] = 0;
         for (int c = 0; c < 4; c++) h[r] += q_at(r, c) * vec[c];
      end
      pass = (FLIP_MODE != 0) ? (h[2] < 0) : (h[2] > 0);
      if (!pass) return;
      sat = 1'b0;
      pt.xyz[31:0]  = divide_q16(h[0], h[3], sat);
      pt.xyz[63:32] = divide_q16(h[1], h[3], sat);
      pt.xyz[95:64] = divide_q16(h[2], h[3], sat);
      pt.rgb = word[63:40];
      pt.sat = sat;
      expected_points.insert(expected_points.size(), pt);
   endfunction

   // Check each accepted point word against the oldest prediction
   always @(posedge clock) begin
      point_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.xyz = rsp_tdata[95:0];
         got.rgb = rsp_tdata[119:96];
         got.sat = rsp_tuser;
         if (expected_points.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected point word %h", got);
         end else begin
            want = expected_points.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch exp x=%h y=%h z=%h c=%h s=%b got x=%h y=%h z=%h c=%h s=%b",
                     want.xyz[31:0], want.xyz[63:32], want.xyz[95:64], want.rgb, want.sat,
                     got.xyz[31:0], got.xyz[63:32], got.xyz[95:64], got.rgb, got.sat);
            end
         end
      end
   end

   // Random receiver stalls
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic send_pixel(logic [11:0] col, logic [11:0] row, logic [15:0] disp,
                             logic [23:0] rgb);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {rgb, disp, row, col};
      do @(posedge clock); while (!req_tready);
      project_pixel({rgb, disp, row, col});
   endtask

   task automatic drain_points();
      req_tvalid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_matrix_reg(int idx, logic [63:0] value);
      csr_we <= 1'b1;
      csr_index <= CSR_IDX_W'(idx);
      csr_wdata <= value;
      @(posedge clock);
      q_matrix[idx] = value;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [63:0] pack_pair(int even_q, int odd_q);
      return {32'(odd_q), 32'(even_q)};
   endfunction

   // Typical pinhole reprojection: x=col-cx, y=row-cy, z=f, w=d/B
   task automatic load_camera_matrix(int f_q, int cx_q, int cy_q, int inv_b_q);
      write_matrix_reg(0, pack_pair(32'h10000, 0));
      write_matrix_reg(1, pack_pair(0, -cx_q));
      write_matrix_reg(2, pack_pair(0, 32'h10000));
      write_matrix_reg(3, pack_pair(0, -cy_q));
      write_matrix_reg(4, pack_pair(0, 0));
      write_matrix_reg(5, pack_pair(0, f_q));
      write_matrix_reg(6, pack_pair(0, 0));
      write_matrix_reg(7, pack_pair(inv_b_q, 0));
   endtask

   task automatic load_random_matrix();
      for (int i = 0; i < NUM_REGS; i++)
         write_matrix_reg(i, {$urandom(), $urandom()});
   endtask

   task automatic send_random_pixel(int valid_pct);
      logic [15:0] disp;
      disp = ($urandom_range(99) < valid_pct) ? 16'($urandom_range(32767, 1)) : 16'($urandom());
      send_pixel(12'($urandom()), 12'($urandom()), disp, 24'($urandom()));
   endtask

   // Field extremes, invalid disparity, W zero and clipping
   task automatic test_directed();
      load_camera_matrix(32'h0200_0000, 32'h0140_0000, 32'h00F0_0000, 32'h0000_4000);
      send_pixel(12'd0, 12'd0, 16'sd16, 24'h000000);
      send_pixel(12'hFFF, 12'hFFF, 16'sh7FFF, 24'hFFFFFF);
      send_pixel(12'd320, 12'd240, 16'sd1, 24'h123456);
      send_pixel(12'hAAA, 12'h555, 16'sh5555, 24'hA5A55A);
      send_pixel(12'h555, 12'hAAA, 16'shAAAA, 24'h5A5AA5);  // negative: invalid pixel
      send_pixel(12'd10, 12'd10, 16'sd0, 24'h808080);
      send_pixel(12'd10, 12'd10, 16'sh8000, 24'h010203);
      send_pixel(12'd10, 12'd10, 16'shFFFF, 24'h040506);
      drain_points();
      // W forced to zero: every point saturates
      write_matrix_reg(7, 64'd0);
      write_matrix_reg(6, 64'd0);
      send_pixel(12'd100, 12'd50, 16'sd64, 24'h111111);
      send_pixel(12'd0, 12'd0, 16'sd64, 24'h222222);
      send_pixel(12'd0, 12'd0, 16'sd0, 24'h333333);
      drain_points();
      // Extreme entries: all ones, all most-negative, all most-positive
      for (int i = 0; i < NUM_REGS; i++) write_matrix_reg(i, '1);
      send_pixel(12'hFFF, 12'hFFF, 16'sh7FFF, 24'hFEDCBA);
      send_pixel(12'd1, 12'd1, 16'sd0, 24'h0F0F0F);
      drain_points();
      for (int i = 0; i < NUM_REGS; i++) write_matrix_reg(i, 64'h8000_0000_8000_0000);
      send_pixel(12'hFFF, 12'hFFF, 16'sh7FFF, 24'h445566);
      send_pixel(12'd0, 12'd0, 16'sd0, 24'h778899);
      drain_points();
      for (int i = 0; i < NUM_REGS; i++) write_matrix_reg(i, 64'h7FFF_FFFF_7FFF_FFFF);
      send_pixel(12'hFFF, 12'h000, 16'sd1, 24'hCCBBAA);
      send_pixel(12'd0, 12'hFFF, 16'sh7FFF, 24'h998877);
      drain_points();
   endtask

   // Random pixels under one idling and stalling setting, mostly with a camera-like matrix
   task automatic test_random_phase(int idle_pct, int stall_pct, int pixels, bit random_q);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      if (random_q) load_random_matrix();
      else load_camera_matrix(32'h0100_0000 + $urandom_range(32'hFFFFFF),
                              $urandom_range(32'h0800_0000), $urandom_range(32'h0800_0000),
                              $urandom_range(32'h0001_0000, 1));
      for (int i = 0; i < pixels; i++) send_random_pixel(80);
      drain_points();
   endtask

   // Hold the sender until every point is back, then resume
   task automatic test_sender_pause();
      send_idle_pct = 0;
      recv_stall_pct = 50;
      for (int i = 0; i < 20; i++) send_random_pixel(90);
      req_tvalid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      for (int i = 0; i < 20; i++) send_random_pixel(90);
      drain_points();
   endtask

   initial begin
      for (int i = 0; i < NUM_REGS; i++) q_matrix[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_phase(0, 0, 100, 0);
      test_random_phase(86, 0, 80, 0);
      test_random_phase(0, 86, 80, 1);
      test_random_phase(13, 13, 100, 0);
      test_random_phase(0, 0, 60, 1);
      test_sender_pause();
      if (mismatch_count == 0 && expected_points.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
